@@ design/assert_macros.svh @@
// Assertion macros used by the checker of the block.
// Depends on nothing; include it with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, ignored while reset is active.
`define PCBD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every rising edge, including the reset cycles.
`define PCBD_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/pcbd_pkg.sv @@
// Types, codes and constants for the prefix-compressed block decoder.
// Depends on nothing; every module of the block but pcbd_ram imports it.
package pcbd_pkg;

    // Default capacity of the key store in bytes.
    localparam int DEF_MAX_KEY_BYTES = 32;

    // Varint framing: bit 7 of a byte says that another byte follows.
    localparam int VARINT_CONT_BIT = 7;
    // Index of the fifth varint byte, the last one a varint may have.
    localparam logic [2:0] LAST_VARINT_IDX = 3'd4;

    // Result kinds.
    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_KEY    = 2'd1;
    localparam logic [1:0] KIND_VALUE  = 2'd2;
    localparam logic [1:0] KIND_ERROR  = 2'd3;

    // Error codes.
    localparam logic [2:0] ERR_NONE        = 3'd0;
    localparam logic [2:0] ERR_SHARED      = 3'd1;
    localparam logic [2:0] ERR_KEY_LONG    = 3'd2;
    localparam logic [2:0] ERR_LONG_VARINT = 3'd3;
    localparam logic [2:0] ERR_TRUNCATED   = 3'd4;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       region_end;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data_byte;
        logic [5:0]  key_length;
        logic [31:0] value_len;
        logic [2:0]  error_code;
        logic        entry_end;
        logic        last;
    } t_out_item;

    // Position inside one entry.
    typedef enum logic [2:0] {
        PH_SHARED,
        PH_NONSHARED,
        PH_VALLEN,
        PH_KEY,
        PH_VALUE
    } t_phase;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_REPLAY,
        ST_TRUNC
    } t_ctrl_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;          // capture the input item
        logic exec;           // apply the byte's decode step
        logic replay_active;  // controller is replaying the shared prefix
        logic replay_push;    // push one prefix byte
        logic trunc_push;     // push the truncation error
        logic finish;         // item done; clear state if it ended the region
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic has_result;     // the decode step yields a result
        logic replay;         // the decode step starts a prefix replay
        logic trunc_now;      // truncation error follows the decode step
        logic trunc_pend;     // registered truncation flag for after replay
        logic replay_last;    // the current prefix byte is the final one
        logic slot_free;      // output register can take a result
    } t_dp_status;

endpackage

@@ design/pcbd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module pcbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ design/pcbd_ctrl.sv @@
// Controller state machine: sequences accept, decode, prefix replay and
// the truncation error. Depends on pcbd_pkg.
module pcbd_ctrl
    import pcbd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_ctrl_state r_state;
    t_ctrl_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (!i_status.has_result || i_status.slot_free) begin
                    o_cmd.exec = 1'b1;
                    if (i_status.replay) begin
                        n_state = ST_REPLAY;
                    end else if (i_status.trunc_now) begin
                        n_state = ST_TRUNC;
                    end else begin
                        o_cmd.finish = 1'b1;
                        n_state      = ST_IDLE;
                    end
                end
            end
            ST_REPLAY: begin
                o_cmd.replay_active = 1'b1;
                if (i_status.slot_free) begin
                    o_cmd.replay_push = 1'b1;
                    if (i_status.replay_last) begin
                        if (i_status.trunc_pend) begin
                            n_state = ST_TRUNC;
                        end else begin
                            o_cmd.finish = 1'b1;
                            n_state      = ST_IDLE;
                        end
                    end
                end
            end
            ST_TRUNC: begin
                if (i_status.slot_free) begin
                    o_cmd.trunc_push = 1'b1;
                    o_cmd.finish     = 1'b1;
                    n_state          = ST_IDLE;
                end
            end
        endcase
    end

endmodule

@@ design/pcbd_datapath.sv @@
// Datapath: varint decode, entry bookkeeping, key store and output register.
// Depends on pcbd_pkg and pcbd_ram.
module pcbd_datapath
    import pcbd_pkg::*;
#(
    parameter int MAX_KEY_BYTES = DEF_MAX_KEY_BYTES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_in_item   i_in_item,
    input  t_dp_cmd    i_cmd,
    output t_dp_status o_status,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_item  o_out_item
);

    localparam int ADDR_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam logic [6:0] MAX_KEY = 7'(MAX_KEY_BYTES);

    // Captured input item.
    logic [7:0]  r_byte;
    logic        r_re;

    // Decode state.
    t_phase      r_phase, n_phase;
    logic [31:0] r_acc, n_acc;
    logic [2:0]  r_cnt, n_cnt;
    logic [5:0]  r_shared, n_shared;
    logic [5:0]  r_keyleft, n_keyleft;
    logic [31:0] r_valleft, n_valleft;
    logic [31:0] r_vlen, n_vlen;
    logic [5:0]  r_stored, n_stored;
    logic        r_err, n_err;
    logic        r_trunc;
    logic [5:0]  r_idx;

    // Output register.
    logic        r_out_valid;
    t_out_item   r_out;

    // Decode step signals.
    t_out_item   x_res;
    logic        x_has_res;
    logic        x_replay;
    logic        x_trunc;
    logic        x_wr_en;
    logic [5:0]  x_pos;
    logic [31:0] x_part;
    logic [31:0] x_acc;
    logic [6:0]  x_sum;
    logic        x_done;
    logic [5:0]  x_klen;
    logic [5:0]  x_kl;
    logic [31:0] x_vl;

    logic [ADDR_W-1:0] rd_addr;
    logic [5:0]        idx_inc;
    logic [7:0]        rd_data;
    t_out_item         rep_res;
    t_out_item         trunc_res;
    t_out_item         push_res;
    logic              push;
    logic              slot_free;

    // The payload bits of a varint byte land at the byte's position; a fifth byte gives only its low four bits.
    always_comb begin
        unique case (r_cnt)
            3'd0:    x_part = {25'd0, r_byte[6:0]};
            3'd1:    x_part = {18'd0, r_byte[6:0], 7'd0};
            3'd2:    x_part = {11'd0, r_byte[6:0], 14'd0};
            3'd3:    x_part = {4'd0, r_byte[6:0], 21'd0};
            3'd4:    x_part = {r_byte[3:0], 28'd0};
            default: x_part = '0;
        endcase
    end

    always_comb begin
        n_phase   = r_phase;
        n_acc     = r_acc;
        n_cnt     = r_cnt;
        n_shared  = r_shared;
        n_keyleft = r_keyleft;
        n_valleft = r_valleft;
        n_vlen    = r_vlen;
        n_stored  = r_stored;
        n_err     = r_err;
        x_res     = '0;
        x_has_res = 1'b0;
        x_replay  = 1'b0;
        x_wr_en   = 1'b0;
        x_acc     = r_acc | x_part;
        x_sum     = {1'b0, r_shared} + {1'b0, x_acc[5:0]};
        x_done    = (r_keyleft == 6'd0) && (x_acc == 32'd0);
        x_klen    = r_shared + r_keyleft;
        x_pos     = r_stored - r_keyleft;
        x_kl      = r_keyleft - 6'd1;
        x_vl      = r_valleft - 32'd1;
        if (!r_err) begin
            unique case (r_phase)
                PH_SHARED, PH_NONSHARED, PH_VALLEN: begin
                    if (r_byte[VARINT_CONT_BIT]) begin
                        n_acc = x_acc;
                        n_cnt = r_cnt + 3'd1;
                        if (r_cnt == LAST_VARINT_IDX) begin
                            n_err            = 1'b1;
                            x_has_res        = 1'b1;
                            x_res.kind       = KIND_ERROR;
                            x_res.error_code = ERR_LONG_VARINT;
                        end
                    end else begin
                        n_acc = '0;
                        n_cnt = '0;
                        if (r_phase == PH_SHARED) begin
                            if ((|x_acc[31:6]) || (x_acc[5:0] > r_stored)) begin
                                n_err            = 1'b1;
                                x_has_res        = 1'b1;
                                x_res.kind       = KIND_ERROR;
                                x_res.error_code = ERR_SHARED;
                            end else begin
                                n_shared = x_acc[5:0];
                                n_phase  = PH_NONSHARED;
                            end
                        end else if (r_phase == PH_NONSHARED) begin
                            if ((|x_acc[31:6]) || (x_sum > MAX_KEY)) begin
                                n_err            = 1'b1;
                                x_has_res        = 1'b1;
                                x_res.kind       = KIND_ERROR;
                                x_res.error_code = ERR_KEY_LONG;
                            end else begin
                                n_keyleft = x_acc[5:0];
                                n_phase   = PH_VALLEN;
                            end
                        end else begin
                            // Value length closes the header.
                            n_valleft          = x_acc;
                            n_vlen             = x_acc;
                            n_stored           = x_klen;
                            x_has_res          = 1'b1;
                            x_res.kind         = KIND_HEADER;
                            x_res.key_length   = x_klen;
                            x_res.value_len    = x_acc;
                            x_res.entry_end    = x_done && (r_shared == 6'd0);
                            x_replay           = (r_shared != 6'd0);
                            if (x_done) begin
                                n_phase = PH_SHARED;
                            end else if (r_keyleft != 6'd0) begin
                                n_phase = PH_KEY;
                            end else begin
                                n_phase = PH_VALUE;
                            end
                        end
                    end
                end
                PH_KEY: begin
                    x_wr_en            = 1'b1;
                    n_keyleft          = x_kl;
                    x_has_res          = 1'b1;
                    x_res.kind         = KIND_KEY;
                    x_res.data_byte    = r_byte;
                    x_res.key_length   = r_stored;
                    x_res.value_len    = r_vlen;
                    x_res.entry_end    = (x_kl == 6'd0) && (r_vlen == 32'd0);
                    if (x_kl == 6'd0) begin
                        n_phase = (r_vlen != 32'd0) ? PH_VALUE : PH_SHARED;
                    end
                end
                PH_VALUE: begin
                    n_valleft          = x_vl;
                    x_has_res          = 1'b1;
                    x_res.kind         = KIND_VALUE;
                    x_res.data_byte    = r_byte;
                    x_res.key_length   = r_stored;
                    x_res.value_len    = r_vlen;
                    x_res.entry_end    = (x_vl == 32'd0);
                    if (x_vl == 32'd0) begin
                        n_phase = PH_SHARED;
                    end
                end
                default: begin
                end
            endcase
        end
        // A region that ends inside an entry gets a truncation error.
        x_trunc    = r_re && !n_err && !((n_phase == PH_SHARED) && (n_cnt == 3'd0));
        x_res.last = !x_replay && !x_trunc;
    end

    // The key store is read one byte ahead during replay.
    assign idx_inc = r_idx + 6'd1;
    always_comb begin
        if (i_cmd.replay_push) begin
            rd_addr = idx_inc[ADDR_W-1:0];
        end else if (i_cmd.replay_active) begin
            rd_addr = r_idx[ADDR_W-1:0];
        end else begin
            rd_addr = '0;
        end
    end

    pcbd_ram #(
        .WIDTH(8),
        .DEPTH(MAX_KEY_BYTES)
    ) u_key_store (
        .i_clk    (i_clk),
        .i_wr_en  (x_wr_en && i_cmd.exec),
        .i_wr_addr(x_pos[ADDR_W-1:0]),
        .i_wr_data(r_byte),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    always_comb begin
        rep_res              = '0;
        rep_res.kind         = KIND_KEY;
        rep_res.data_byte    = rd_data;
        rep_res.key_length   = r_stored;
        rep_res.value_len    = r_vlen;
        rep_res.entry_end    = (idx_inc == r_shared) && (r_keyleft == 6'd0)
                               && (r_valleft == 32'd0);
        rep_res.last         = (idx_inc == r_shared) && !r_trunc;
    end

    always_comb begin
        trunc_res            = '0;
        trunc_res.kind       = KIND_ERROR;
        trunc_res.error_code = ERR_TRUNCATED;
        trunc_res.last       = 1'b1;
    end

    assign slot_free = !r_out_valid || !i_out_stall;
    assign push = (i_cmd.exec && x_has_res) || i_cmd.replay_push || i_cmd.trunc_push;

    always_comb begin
        if (i_cmd.exec) begin
            push_res = x_res;
        end else if (i_cmd.replay_push) begin
            push_res = rep_res;
        end else begin
            push_res = trunc_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_byte <= i_in_item.in_byte;
        end
        if (push) begin
            r_out <= push_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_re        <= 1'b0;
            r_phase     <= PH_SHARED;
            r_acc       <= '0;
            r_cnt       <= '0;
            r_shared    <= '0;
            r_keyleft   <= '0;
            r_valleft   <= '0;
            r_vlen      <= '0;
            r_stored    <= '0;
            r_err       <= 1'b0;
            r_trunc     <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.latch) begin
                r_re <= i_in_item.region_end;
            end
            // The end of a region clears the decode state, even on the decode step.
            if (i_cmd.finish && r_re) begin
                r_phase   <= PH_SHARED;
                r_acc     <= '0;
                r_cnt     <= '0;
                r_shared  <= '0;
                r_keyleft <= '0;
                r_valleft <= '0;
                r_vlen    <= '0;
                r_stored  <= '0;
                r_err     <= 1'b0;
            end else if (i_cmd.exec) begin
                r_phase   <= n_phase;
                r_acc     <= n_acc;
                r_cnt     <= n_cnt;
                r_shared  <= n_shared;
                r_keyleft <= n_keyleft;
                r_valleft <= n_valleft;
                r_vlen    <= n_vlen;
                r_stored  <= n_stored;
                r_err     <= n_err;
            end
            if (i_cmd.exec) begin
                r_trunc <= x_trunc;
                r_idx   <= '0;
            end else if (i_cmd.replay_push) begin
                r_idx <= idx_inc;
            end
            if (push) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_status.has_result  = x_has_res;
        o_status.replay      = x_replay;
        o_status.trunc_now   = x_trunc;
        o_status.trunc_pend  = r_trunc;
        o_status.replay_last = (idx_inc == r_shared);
        o_status.slot_free   = slot_free;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

@@ design/prefix_compressed_block_decoder.sv @@
// An accepted byte is captured, then decoded in the EXEC state, which writes its first
// result into the output register. No new byte is taken until the last one is done; a
// header byte of an entry that reuses S prefix bytes also replays them, one per cycle from
// the single key store read port, then any truncation error; a full output stalls each push.
// Reset (synchronous, active low) clears all control state; the key store keeps its
// contents and is only read where the current stored key was written.
module prefix_compressed_block_decoder
    import pcbd_pkg::*;
#(
    parameter int MAX_KEY_BYTES = DEF_MAX_KEY_BYTES
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    // The controller takes one byte at a time. Each byte is first captured,
    // then decoded in one step that may emit a header, key, value or error
    // item. A header whose entry shares a prefix with the previous key is
    // followed by the shared bytes, replayed from the key store one per cycle
    // while the output is free. A byte that ends the region inside an unfinished
    // entry adds a truncation error; after such a byte all decode state is cleared.
    //
    // The output register sits between the decoder and the consumer, so a new
    // byte is taken while an earlier item still waits to be picked up.

    t_dp_cmd    cmd;
    t_dp_status status;

    pcbd_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_status  (status),
        .o_cmd     (cmd)
    );

    pcbd_datapath #(
        .MAX_KEY_BYTES(MAX_KEY_BYTES)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_item  (i_in_item),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item (o_out_item)
    );

endmodule

@@ design/pcbd_checker.sv @@
// Port-level checker for the prefix-compressed block decoder and its bind.
// Depends on pcbd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pcbd_checker
    import pcbd_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_item  i_in_item,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    // A result that waits on a stalled consumer stays put.
    `PCBD_ASSERT(a_out_hold, i_clk, i_rst_n, (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_item)), "stalled output item changed")

    // The block works on one byte at a time: an accept closes the input.
    `PCBD_ASSERT(a_one_at_a_time, i_clk, i_rst_n, (i_in_valid && !o_in_stall) |=> o_in_stall, "input accepted on consecutive cycles")

    // Reset empties the output register.
    `PCBD_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_out_valid, "output valid after reset")

endmodule

bind prefix_compressed_block_decoder pcbd_checker u_pcbd_checker (.*);

@@ tb/sv/tb_prefix_compressed_block_decoder.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for prefix_compressed_block_decoder: directed table bytes,
// then random regions of entries, checked by a built-in entry decoder or the table.
// Depends on pcbd_pkg and the decoder RTL only.
module tb_prefix_compressed_block_decoder;
    import pcbd_pkg::*;

    localparam int KEY_BYTES_MAX = DEF_MAX_KEY_BYTES;
    localparam int VARINT_MAX_BYTES = 5;
    localparam int RANDOM_ITEMS = 195;
    localparam int MAX_WAIT = 14;
    localparam int DRAIN_CYCLES = 100;
    localparam int REPORT_LIMIT = 10;
    // Worst case is roughly 250 items, each waiting out a full sender gap and then
    // 34 results that each sit through a full receiver stall.
    localparam int TIMEOUT_NS = 10_000_000;

    // How a stimulus row is checked. Most rows go through the decoder model below;
    // a few rows carry the answer in the table: no result, or one error item.
    typedef enum logic [1:0] {
        FROM_DECODER,
        FIXED_NONE,
        FIXED_ONE
    } t_row_check;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       region_end;
        t_row_check chk;
        logic [2:0] err;
    } t_stim_row;

    // Directed bytes. Error rows are typed in; the good entries at the end are left
    // to the decoder model.
    localparam int DIRECTED_ROWS = 25;
    localparam t_stim_row DIRECTED [DIRECTED_ROWS] = '{
        // Shared length of one against an empty stored key.
        '{8'h01, 1'b0, FIXED_ONE,    ERR_SHARED},
        // While the error holds, bytes are dropped; region end clears it silently.
        '{8'hFF, 1'b1, FIXED_NONE,   ERR_NONE},
        // Five continuation bytes in a row make a varint that is too long.
        '{8'h80, 1'b0, FIXED_NONE,   ERR_NONE},
        '{8'h80, 1'b0, FIXED_NONE,   ERR_NONE},
        '{8'h80, 1'b0, FIXED_NONE,   ERR_NONE},
        '{8'h80, 1'b0, FIXED_NONE,   ERR_NONE},
        '{8'h80, 1'b0, FIXED_ONE,    ERR_LONG_VARINT},
        '{8'h00, 1'b1, FIXED_NONE,   ERR_NONE},
        // No shared bytes, then 33 new key bytes: one more than the store holds.
        '{8'h00, 1'b0, FIXED_NONE,   ERR_NONE},
        '{8'h21, 1'b0, FIXED_ONE,    ERR_KEY_LONG},
        '{8'h55, 1'b1, FIXED_NONE,   ERR_NONE},
        // The region ends right after a shared length: the entry is truncated.
        '{8'h00, 1'b1, FIXED_ONE,    ERR_TRUNCATED},
        // A one-byte key with a one-byte value.
        '{8'h00, 1'b0, FROM_DECODER, ERR_NONE},
        '{8'h01, 1'b0, FROM_DECODER, ERR_NONE},
        '{8'h01, 1'b0, FROM_DECODER, ERR_NONE},
        '{8'h3C, 1'b0, FROM_DECODER, ERR_NONE},
        '{8'hA5, 1'b0, FROM_DECODER, ERR_NONE},
        // Reuse the whole key, and give the largest value length as a five-byte
        // varint whose top bits fall off; then cut the value short.
        '{8'h01, 1'b0, FROM_DECODER, ERR_NONE},
        '{8'h00, 1'b0, FROM_DECODER, ERR_NONE},
        '{8'hFF, 1'b0, FROM_DECODER, ERR_NONE},
        '{8'hFF, 1'b0, FROM_DECODER, ERR_NONE},
        '{8'hFF, 1'b0, FROM_DECODER, ERR_NONE},
        '{8'hFF, 1'b0, FROM_DECODER, ERR_NONE},
        '{8'h7F, 1'b0, FROM_DECODER, ERR_NONE},
        '{8'h7E, 1'b1, FROM_DECODER, ERR_NONE}
    };

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_item = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_item;

    prefix_compressed_block_decoder #(
        .MAX_KEY_BYTES(KEY_BYTES_MAX)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item (o_out_item)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Entry decoder model. It keeps its own copy of the key store and of the
    // entry parsing state, and turns one input byte into the results it causes.
    // ------------------------------------------------------------------------
    logic [7:0]  key_mem [0:63];
    int          stored_len;
    t_phase      cur_phase;
    logic [31:0] vacc;
    int          vcnt;
    int          shared_n;
    int          key_left;
    logic [31:0] val_left;
    bit          err_on;
    logic [31:0] entry_vlen;
    t_out_item   step_results[$];
    t_out_item   expected_results[$];

    function automatic void push_result(logic [1:0] kind, logic [7:0] data, int klen,
                                        logic [31:0] vlen, logic [2:0] code, bit eend);
        t_out_item r;
        r = '{kind, data, 6'(klen), vlen, code, eend, 1'b0};
        step_results.push_back(r);
    endfunction

    function automatic void raise_decode_error(logic [2:0] code);
        err_on = 1'b1;
        push_result(KIND_ERROR, 8'h00, 0, 32'd0, code, 1'b0);
    endfunction

    function automatic void clear_region();
        stored_len = 0;
        cur_phase = PH_SHARED;
        vacc = '0;
        vcnt = 0;
        shared_n = 0;
        key_left = 0;
        val_left = '0;
        err_on = 1'b0;
        entry_vlen = '0;
    endfunction

    // A varint has just completed; what it means depends on where we are in the entry.
    function automatic void close_varint(logic [31:0] v);
        bit whole;
        case (cur_phase)
            PH_SHARED: begin
                if (v > 32'(stored_len)) begin
                    raise_decode_error(ERR_SHARED);
                end else begin
                    shared_n = int'(v);
                    cur_phase = PH_NONSHARED;
                end
            end
            PH_NONSHARED: begin
                if (64'(shared_n) + 64'(v) > 64'(KEY_BYTES_MAX)) begin
                    raise_decode_error(ERR_KEY_LONG);
                end else begin
                    key_left = int'(v);
                    cur_phase = PH_VALLEN;
                end
            end
            default: begin
                // Value length closes the header: emit it, then replay the prefix.
                whole = (key_left == 0 && v == 0);
                val_left = v;
                entry_vlen = v;
                stored_len = shared_n + key_left;
                push_result(KIND_HEADER, 8'h00, stored_len, v, ERR_NONE,
                            whole && shared_n == 0);
                for (int i = 0; i < shared_n; i++) begin
                    push_result(KIND_KEY, key_mem[i], stored_len, v, ERR_NONE,
                                whole && i + 1 == shared_n);
                end
                if (whole) begin
                    cur_phase = PH_SHARED;
                end else if (key_left != 0) begin
                    cur_phase = PH_KEY;
                end else begin
                    cur_phase = PH_VALUE;
                end
            end
        endcase
    endfunction

    function automatic void decode_byte(t_in_item it);
        logic [63:0] part;
        logic [31:0] v;
        int pos;
        step_results.delete();
        if (!err_on) begin
            if (cur_phase == PH_SHARED || cur_phase == PH_NONSHARED
                    || cur_phase == PH_VALLEN) begin
                // Bits that land above bit 31 are dropped.
                part = {57'd0, it.in_byte[6:0]} << (7 * vcnt);
                vacc |= part[31:0];
                vcnt++;
                if (it.in_byte[VARINT_CONT_BIT]) begin
                    if (vcnt >= VARINT_MAX_BYTES) begin
                        raise_decode_error(ERR_LONG_VARINT);
                    end
                end else begin
                    v = vacc;
                    vacc = '0;
                    vcnt = 0;
                    close_varint(v);
                end
            end else if (cur_phase == PH_KEY) begin
                pos = stored_len - key_left;
                key_mem[pos & 63] = it.in_byte;
                key_left--;
                push_result(KIND_KEY, it.in_byte, stored_len, entry_vlen, ERR_NONE,
                            key_left == 0 && entry_vlen == 0);
                if (key_left == 0) begin
                    cur_phase = (entry_vlen != 0) ? PH_VALUE : PH_SHARED;
                end
            end else begin
                val_left--;
                push_result(KIND_VALUE, it.in_byte, stored_len, entry_vlen, ERR_NONE,
                            val_left == 0);
                if (val_left == 0) begin
                    cur_phase = PH_SHARED;
                end
            end
        end
        if (it.region_end) begin
            // Ending the region in the middle of an entry is a truncation.
            if (!err_on && !(cur_phase == PH_SHARED && vcnt == 0)) begin
                raise_decode_error(ERR_TRUNCATED);
            end
            clear_region();
        end
        if (step_results.size() > 0) begin
            step_results[step_results.size() - 1].last = 1'b1;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Random stimulus. Regions are built byte by byte; shadow_len is the key
    // length that the bytes so far have established, so that well-formed
    // entries never ask for more shared bytes than the stored key has.
    // ------------------------------------------------------------------------
    t_stim_row   stim_rows[$];
    logic [7:0]  region_bytes[$];
    int          shadow_len;
    bit          calm;

    function automatic logic [7:0] any_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // Little-endian base-128; sometimes padded with extra zero groups. In a fifth
    // byte the bits above bit 31 are filled with junk, which the block drops.
    function automatic void put_varint(logic [31:0] v);
        int need;
        int count;
        logic [7:0] b;
        need = 1;
        while (need < VARINT_MAX_BYTES && (v >> (7 * need)) != 0) need++;
        count = ($urandom_range(0, 3) == 0) ? $urandom_range(need, VARINT_MAX_BYTES) : need;
        for (int i = 0; i < count; i++) begin
            b = 8'((v >> (7 * i)) & 32'h7F);
            if (i == VARINT_MAX_BYTES - 1) begin
                b[6:4] = 3'($urandom_range(0, 7));
            end
            if (i < count - 1) begin
                b[VARINT_CONT_BIT] = 1'b1;
            end
            region_bytes.push_back(b);
        end
    endfunction

    function automatic void put_entry();
        int s;
        int n;
        int room;
        int v;
        if (shadow_len == 0) begin
            s = 0;
        end else begin
            s = ($urandom_range(0, 3) == 0) ? shadow_len : $urandom_range(0, shadow_len);
        end
        room = KEY_BYTES_MAX - s;
        // Mostly short keys; now and then the key fills the store completely.
        n = ($urandom_range(0, 7) == 0) ? room : $urandom_range(0, (room < 6) ? room : 6);
        v = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
        put_varint(32'(s));
        put_varint(32'(n));
        put_varint(32'(v));
        repeat (n) region_bytes.push_back(any_byte());
        repeat (v) region_bytes.push_back(any_byte());
        shadow_len = s + n;
    endfunction

    // Moves the region into the stimulus, ending it at byte cut.
    function automatic void close_region(int cut);
        t_stim_row row;
        for (int i = 0; i <= cut; i++) begin
            row = '{region_bytes[i], i == cut, FROM_DECODER, ERR_NONE};
            stim_rows.push_back(row);
        end
        region_bytes.delete();
        shadow_len = 0;
    endfunction

    function automatic void build_random();
        int pick;
        int s;
        int cut;
        shadow_len = 0;
        while (stim_rows.size() < DIRECTED_ROWS + RANDOM_ITEMS) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                // Well-formed region; one in seven is cut off at a random byte.
                repeat ($urandom_range(1, 4)) put_entry();
                cut = (pick == 0) ? $urandom_range(0, region_bytes.size() - 1)
                                  : region_bytes.size() - 1;
            end else begin
                if ($urandom_range(0, 1) == 1) put_entry();
                if (pick == 7) begin
                    repeat ($urandom_range(1, 6)) region_bytes.push_back(any_byte());
                end else if (pick == 8) begin
                    if ($urandom_range(0, 1) == 1) begin
                        put_varint(32'(shadow_len + 1 + $urandom_range(0, 200000)));
                    end else begin
                        s = $urandom_range(0, shadow_len);
                        put_varint(32'(s));
                        put_varint(32'(KEY_BYTES_MAX - s + 1 + $urandom_range(0, 30)));
                    end
                end else begin
                    repeat ($urandom_range(5, 7)) begin
                        region_bytes.push_back(any_byte() | 8'h80);
                    end
                end
                repeat ($urandom_range(0, 3)) region_bytes.push_back(any_byte());
                cut = region_bytes.size() - 1;
            end
            close_region(cut);
        end
    endfunction

    function automatic int draw_wait();
        return calm ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    // ------------------------------------------------------------------------
    // Checking.
    // ------------------------------------------------------------------------
    int fail_count = 0;
    int accepted_count = 0;
    int checked_count = 0;
    int kind_seen [4] = '{0, 0, 0, 0};
    int out_hold = 0;
    t_stim_row took;
    t_out_item fixed_error;

    function automatic string show(t_out_item r);
        return $sformatf("kind %0d data %02h klen %0d vlen %08h err %0d end %0b last %0b",
                         r.kind, r.data_byte, r.key_length, r.value_len,
                         r.error_code, r.entry_end, r.last);
    endfunction

    function automatic void check_result(t_out_item got);
        t_out_item want;
        checked_count++;
        if (got.kind !== 2'bx) kind_seen[got.kind]++;
        if (expected_results.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT) begin
                $display("%0t: result with nothing expected: %s", $realtime, show(got));
            end
            return;
        end
        want = expected_results.pop_front();
        if (got.kind !== want.kind || got.data_byte !== want.data_byte
                || got.key_length !== want.key_length
                || got.value_len !== want.value_len
                || got.error_code !== want.error_code
                || got.entry_end !== want.entry_end || got.last !== want.last) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT) begin
                $display("%0t: result mismatch", $realtime);
                $display("    expected %s", show(want));
                $display("    actual   %s", show(got));
            end
        end
    endfunction

    // Both handshakes are sampled at the rising edge, before any of this edge's
    // updates land, so an accepted item is seen exactly once.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_stall === 1'b0) begin
                took = stim_rows[accepted_count];
                accepted_count++;
                decode_byte('{took.in_byte, took.region_end});
                if (took.chk == FROM_DECODER) begin
                    foreach (step_results[i]) expected_results.push_back(step_results[i]);
                end else if (took.chk == FIXED_ONE) begin
                    fixed_error = '{KIND_ERROR, 8'h00, 6'd0, 32'd0, took.err, 1'b0, 1'b1};
                    expected_results.push_back(fixed_error);
                end
            end
            if (o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
                check_result(o_out_item);
                out_hold = draw_wait();
            end
        end
        // The receiver holds off for a freshly drawn number of cycles after each item.
        if (out_hold > 0) begin
            i_out_stall <= 1'b1;
            out_hold--;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Sender and end of run.
    // ------------------------------------------------------------------------
    initial begin
        int gap;
        clear_region();
        calm = 1'b0;
        for (int i = 0; i < DIRECTED_ROWS; i++) stim_rows.push_back(DIRECTED[i]);
        build_random();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < stim_rows.size(); k++) begin
            // Switch between idle-heavy stretches and stretches at full rate.
            if ($urandom_range(0, 24) == 0) calm = !calm;
            gap = draw_wait();
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_in_valid <= 1'b1;
            i_in_item <= '{stim_rows[k].in_byte, stim_rows[k].region_end};
            do @(posedge i_clk); while (o_in_stall !== 1'b0);
        end
        i_in_valid <= 1'b0;

        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        // Bytes that cause no result may still be in flight.
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (expected_results.size() != 0) begin
            fail_count++;
            $display("%0d expected results never arrived", expected_results.size());
        end
        $display("summary: %0d input items sent (%0d directed), %0d results checked, %0d bad",
                 accepted_count, DIRECTED_ROWS, checked_count, fail_count);
        $display("summary: %0d headers, %0d key bytes, %0d value bytes, %0d error results",
                 kind_seen[KIND_HEADER], kind_seen[KIND_KEY], kind_seen[KIND_VALUE],
                 kind_seen[KIND_ERROR]);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("timeout with %0d results still expected", expected_results.size());
        $display("tb: failure");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+design
design/pcbd_pkg.sv
design/pcbd_ram.sv
design/pcbd_ctrl.sv
design/pcbd_datapath.sv
design/prefix_compressed_block_decoder.sv
design/pcbd_checker.sv
tb/sv/tb_prefix_compressed_block_decoder.sv
